// ----- rtl/core/qecc_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// qecc_pkg: shared types and constants of the edge collapse cost block
// Widths, operand codes, phases and the term tables that drive the sequencer.
// ----------------------------------------------------------------------------
package qecc_pkg;

    localparam int QW       = 33;   // summed quadric coefficient
    localparam int PW       = 32;   // Q16.16 coordinate
    localparam int ACC_W    = 104;  // exact Q56.48 sums of triple products
    localparam int DIV_W    = ACC_W + 32;
    localparam int CNT_W    = $clog2(QW);

    // Operand codes: quadric slots, current point coordinates, constant one.
    localparam logic [3:0] OP_Q0  = 4'd0;
    localparam logic [3:0] OP_Q1  = 4'd1;
    localparam logic [3:0] OP_Q2  = 4'd2;
    localparam logic [3:0] OP_Q3  = 4'd3;
    localparam logic [3:0] OP_Q4  = 4'd4;
    localparam logic [3:0] OP_Q5  = 4'd5;
    localparam logic [3:0] OP_Q6  = 4'd6;
    localparam logic [3:0] OP_Q7  = 4'd7;
    localparam logic [3:0] OP_Q8  = 4'd8;
    localparam logic [3:0] OP_Q9  = 4'd9;
    localparam logic [3:0] OP_PX  = 4'd10;
    localparam logic [3:0] OP_PY  = 4'd11;
    localparam logic [3:0] OP_PZ  = 4'd12;
    localparam logic [3:0] OP_ONE = 4'd13;

    localparam logic [1:0] CH_SOLVED = 2'd0;
    localparam logic [1:0] CH_FIRST  = 2'd1;
    localparam logic [1:0] CH_SECOND = 2'd2;
    localparam logic [1:0] CH_MID    = 2'd3;

    localparam logic [3:0] DET_IDX  [9] = '{4'd0, 4'd1, 4'd2, 4'd1, 4'd4, 4'd5, 4'd2, 4'd5, 4'd7};
    localparam logic [3:0] COFX_IDX [9] = '{4'd1, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd5, 4'd7, 4'd8};
    localparam logic [3:0] COFY_IDX [9] = '{4'd0, 4'd2, 4'd3, 4'd1, 4'd5, 4'd6, 4'd2, 4'd7, 4'd8};
    localparam logic [3:0] COFZ_IDX [9] = '{4'd0, 4'd1, 4'd3, 4'd1, 4'd4, 4'd6, 4'd2, 4'd5, 4'd8};

    typedef enum logic [2:0] {
        PH_DET,
        PH_COFX,
        PH_COFY,
        PH_COFZ,
        PH_EVAL
    } t_phase;

    // One term: sign * a * b * c << sh.
    typedef struct packed {
        logic [3:0] a;
        logic [3:0] b;
        logic [3:0] c;
        logic       sub;
        logic [5:0] sh;
    } t_term;

    typedef struct packed {
        logic                    start;
        logic signed [ACC_W-1:0] mcand;
        logic signed [QW-1:0]    mplier;
    } t_mul_req;

    typedef struct packed {
        logic start;
        logic flip;
    } t_div_req;

    function automatic logic [3:0] idx_of(input t_phase ph, input logic [3:0] p);
        logic [3:0] r;
        unique case (ph)
            PH_COFX: r = COFX_IDX[p];
            PH_COFY: r = COFY_IDX[p];
            PH_COFZ: r = COFZ_IDX[p];
            default: r = DET_IDX[p];
        endcase
        return r;
    endfunction

    function automatic logic [3:0] term_last(input t_phase ph);
        return (ph == PH_EVAL) ? 4'd9 : 4'd5;
    endfunction

    function automatic t_term term_of(input t_phase ph, input logic [3:0] k);
        t_term      t;
        logic [3:0] r0;
        logic [3:0] r1;
        logic [3:0] r2;
        t  = '0;
        r0 = 4'd0;
        r1 = 4'd4;
        r2 = 4'd8;
        if (ph == PH_EVAL) begin
            case (k)
                4'd0:    t = '{OP_Q0, OP_PX, OP_PX,  1'b0, 6'd0};
                4'd1:    t = '{OP_Q4, OP_PY, OP_PY,  1'b0, 6'd0};
                4'd2:    t = '{OP_Q7, OP_PZ, OP_PZ,  1'b0, 6'd0};
                4'd3:    t = '{OP_Q1, OP_PX, OP_PY,  1'b0, 6'd1};
                4'd4:    t = '{OP_Q2, OP_PX, OP_PZ,  1'b0, 6'd1};
                4'd5:    t = '{OP_Q5, OP_PY, OP_PZ,  1'b0, 6'd1};
                4'd6:    t = '{OP_Q3, OP_PX, OP_ONE, 1'b0, 6'd17};
                4'd7:    t = '{OP_Q6, OP_PY, OP_ONE, 1'b0, 6'd17};
                4'd8:    t = '{OP_Q8, OP_PZ, OP_ONE, 1'b0, 6'd17};
                4'd9:    t = '{OP_Q9, OP_ONE, OP_ONE, 1'b0, 6'd32};
                default: t = '0;
            endcase
        end else begin
            case (k)
                4'd1:    begin r0 = 4'd2; r1 = 4'd3; r2 = 4'd7; end
                4'd2:    begin r0 = 4'd1; r1 = 4'd5; r2 = 4'd6; end
                4'd3:    begin r0 = 4'd2; r1 = 4'd4; r2 = 4'd6; end
                4'd4:    begin r0 = 4'd0; r1 = 4'd5; r2 = 4'd7; end
                4'd5:    begin r0 = 4'd1; r1 = 4'd3; r2 = 4'd8; end
                default: begin r0 = 4'd0; r1 = 4'd4; r2 = 4'd8; end
            endcase
            t.a   = idx_of(ph, r0);
            t.b   = idx_of(ph, r1);
            t.c   = idx_of(ph, r2);
            t.sub = (k >= 4'd3);
            t.sh  = 6'd0;
        end
        return t;
    endfunction

endpackage
`default_nettype wire

// ----- rtl/core/qecc_mul.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// qecc_mul: bit-serial signed multiplier
// Shift-and-add over the 33 bits of the multiplier, one wide add per cycle.
// ----------------------------------------------------------------------------
module qecc_mul (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire qecc_pkg::t_mul_req                i_req,
    output logic                                   o_done,
    output logic signed [qecc_pkg::ACC_W-1:0]      o_prod
);

    logic signed [qecc_pkg::ACC_W-1:0] r_m;
    logic signed [qecc_pkg::ACC_W-1:0] r_p;
    logic        [qecc_pkg::QW-1:0]    r_b;
    logic        [qecc_pkg::CNT_W-1:0] r_cnt;
    logic                              r_busy;
    logic                              r_done;
    logic signed [qecc_pkg::ACC_W-1:0] addend;
    logic                              last_bit;

    assign addend   = r_b[0] ? r_m : '0;
    // The top bit of the multiplier carries negative weight.
    assign last_bit = (r_cnt == qecc_pkg::CNT_W'(qecc_pkg::QW - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_m    <= i_req.mcand;
                r_b    <= i_req.mplier;
                r_p    <= '0;
                r_cnt  <= '0;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_p   <= last_bit ? (r_p - addend) : (r_p + addend);
                r_m   <= r_m <<< 1;
                r_b   <= r_b >> 1;
                r_cnt <= r_cnt + 1'b1;
                if (last_bit) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_prod = r_p;

endmodule
`default_nettype wire

// ----- rtl/core/qecc_div.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// qecc_div: restoring divider for the solved coordinates
// Computes (cofactor << 16) / det, truncated and saturated to Q16.16.
// ----------------------------------------------------------------------------
module qecc_div (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire qecc_pkg::t_div_req                   i_req,
    input  wire logic signed [qecc_pkg::ACC_W-1:0]    i_num,
    input  wire logic signed [qecc_pkg::ACC_W-1:0]    i_den,
    output logic                                      o_done,
    output logic signed [qecc_pkg::PW-1:0]            o_quot
);

    logic [qecc_pkg::DIV_W-1:0] r_rem;
    logic [qecc_pkg::DIV_W-1:0] r_d;
    logic [qecc_pkg::PW-1:0]    r_q;
    logic [5:0]                 r_cnt;
    logic                       r_neg;
    logic                       r_run;
    logic                       r_done;
    logic [qecc_pkg::PW-1:0]    r_quot;

    logic [qecc_pkg::ACC_W-1:0] abs_num;
    logic [qecc_pkg::ACC_W-1:0] abs_den;
    logic                       ge;
    logic [qecc_pkg::PW-1:0]    n_q;
    logic [qecc_pkg::PW-1:0]    fin;

    assign abs_num = i_num[qecc_pkg::ACC_W-1] ? -i_num : i_num;
    assign abs_den = i_den[qecc_pkg::ACC_W-1] ? -i_den : i_den;
    assign ge      = (r_rem >= r_d);
    assign n_q     = {r_q[qecc_pkg::PW-2:0], ge};

    always_comb begin
        if (r_neg) begin
            fin = (n_q > 32'h8000_0000) ? 32'h8000_0000 : -n_q;
        end else begin
            fin = n_q[qecc_pkg::PW-1] ? 32'h7FFF_FFFF : n_q;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_rem <= {16'd0, abs_num, 16'd0};
                r_d   <= {abs_den, 32'd0};
                r_q   <= '0;
                r_cnt <= '0;
                r_neg <= (i_num[qecc_pkg::ACC_W-1] != i_den[qecc_pkg::ACC_W-1]) != i_req.flip;
                r_run <= 1'b1;
            end else if (r_run) begin
                if (r_cnt == 6'd0) begin
                    // A quotient of 2^32 or more saturates at once.
                    if (ge) begin
                        r_quot <= r_neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
                        r_run  <= 1'b0;
                        r_done <= 1'b1;
                    end
                end else begin
                    if (ge) begin
                        r_rem <= r_rem - r_d;
                    end
                    r_q <= n_q;
                    if (r_cnt == 6'd32) begin
                        r_quot <= fin;
                        r_run  <= 1'b0;
                        r_done <= 1'b1;
                    end
                end
                r_d   <= r_d >> 1;
                r_cnt <= r_cnt + 1'b1;
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule
`default_nettype wire

// ----- rtl/core/quadric_edge_collapse_cost.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// quadric_edge_collapse_cost: fixed-point quadric error cost of one edge collapse
// Sums two quadrics, solves for the optimal position or picks the best of the
// endpoints and midpoint, and reports the error with the chosen position.
// ----------------------------------------------------------------------------
// Usage. The input channel carries one word per slot: slots 0 to 9 are the
// quadric coefficients of both vertices, slots 10 to 12 the x, y and z of
// both endpoints; slots 13 to 15 store nothing. Each word is taken only
// while the block is idle. A word with last set starts the evaluation,
// and one result word follows on the output channel.
// The evaluation is a sequence of terms of the form a * b * c, each computed
// by one shared bit-serial multiplier in two passes. A solvable edge takes
// 34 terms and three divisions (a division ends early when the quotient
// saturates at once), a singular one 36 terms. From the taking of the
// last word until the result is loaded, o_in_stall is high; the load
// waits only while the previous result is still stalled.
// The result sits in an output register. While the receiver stalls it holds
// its word, and the block may still take the words of the next edge; only a
// new result waits until the output register is free.
// Reset clears the sequencer and the output valid. Quadric and point storage
// is not cleared and must be loaded before it is used.
// ----------------------------------------------------------------------------
module quadric_edge_collapse_cost (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire logic        [3:0]  i_slot,
    input  wire logic signed [31:0] i_first_value,
    input  wire logic signed [31:0] i_second_value,
    input  wire logic               i_last,
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output logic signed [63:0]      o_cost,
    output logic signed [31:0]      o_pos_x,
    output logic signed [31:0]      o_pos_y,
    output logic signed [31:0]      o_pos_z,
    output logic        [1:0]       o_choice
);

    localparam int QW    = qecc_pkg::QW;
    localparam int PW    = qecc_pkg::PW;
    localparam int ACC_W = qecc_pkg::ACC_W;

    typedef enum logic [3:0] {
        S_IDLE,
        S_TERM_A,
        S_TERM_B,
        S_MUL1,
        S_TERM_C,
        S_MUL2,
        S_PHASE_END,
        S_DIV,
        S_OUT
    } t_state;

    t_state                  r_state;
    qecc_pkg::t_phase        r_phase;
    logic [3:0]              r_term;
    logic [1:0]              r_cand;

    logic signed [QW-1:0]    r_q      [10];
    logic signed [PW-1:0]    r_first  [3];
    logic signed [PW-1:0]    r_second [3];
    logic signed [PW-1:0]    r_p      [3];
    logic signed [PW-1:0]    r_bpos   [3];
    logic [1:0]              r_bch;
    logic signed [QW-1:0]    r_ma;
    logic signed [ACC_W-1:0] r_acc;
    logic signed [ACC_W-1:0] r_det;
    logic signed [ACC_W-1:0] r_best;

    logic                    r_ovalid;
    logic signed [63:0]      r_o_cost;
    logic signed [PW-1:0]    r_o_pos [3];
    logic [1:0]              r_o_choice;

    qecc_pkg::t_term         term;
    logic [3:0]              opnd_code;
    logic [1:0]              p_idx;
    logic signed [QW-1:0]    opnd_val;
    logic signed [PW-1:0]    mid [3];
    logic signed [QW-1:0]    mid_sum [3];
    logic signed [ACC_W-1:0] cost_sh;
    logic signed [63:0]      cost_sat;
    logic                    in_take;
    logic                    out_load;
    logic                    take_cand;

    qecc_pkg::t_mul_req      mul_req;
    logic                    mul_done;
    logic signed [ACC_W-1:0] mul_prod;
    qecc_pkg::t_div_req      div_req;
    logic                    div_done;
    logic signed [PW-1:0]    div_quot;

    assign term    = qecc_pkg::term_of(r_phase, r_term);
    assign in_take = i_in_valid && (r_state == S_IDLE);

    // A single operand is fetched per cycle: a, then b, then c once the first product is done.
    always_comb begin
        case (r_state)
            S_TERM_A: opnd_code = term.a;
            S_TERM_B: opnd_code = term.b;
            default:  opnd_code = term.c;
        endcase
        p_idx = 2'(opnd_code - qecc_pkg::OP_PX);
        if (opnd_code <= qecc_pkg::OP_Q9) begin
            opnd_val = r_q[opnd_code];
        end else if (opnd_code <= qecc_pkg::OP_PZ) begin
            opnd_val = {r_p[p_idx][PW-1], r_p[p_idx]};
        end else if (opnd_code == qecc_pkg::OP_ONE) begin
            opnd_val = QW'(1);
        end else begin
            opnd_val = '0;
        end
    end

    always_comb begin
        mul_req.start  = (r_state == S_TERM_B) || (r_state == S_TERM_C);
        mul_req.mplier = opnd_val;
        if (r_state == S_TERM_B) begin
            mul_req.mcand = {{(ACC_W-QW){r_ma[QW-1]}}, r_ma};
        end else begin
            mul_req.mcand = mul_prod <<< term.sh;
        end
    end

    // Division starts when a cofactor sum is complete; x and z flip sign.
    assign div_req.start = (r_state == S_PHASE_END) &&
                           ((r_phase == qecc_pkg::PH_COFX) ||
                            (r_phase == qecc_pkg::PH_COFY) ||
                            (r_phase == qecc_pkg::PH_COFZ));
    assign div_req.flip  = (r_phase != qecc_pkg::PH_COFY);

    qecc_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mul_req),
        .o_done  (mul_done),
        .o_prod  (mul_prod)
    );

    qecc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .i_num   (r_acc),
        .i_den   (r_det),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    // Midpoint is the floor of half the exact sum.
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            mid_sum[i] = {r_first[i][PW-1], r_first[i]} + {r_second[i][PW-1], r_second[i]};
            mid[i]     = mid_sum[i][QW-1:1];
        end
    end

    // The second endpoint and the midpoint replace the best one on ties, so the later one wins.
    assign take_cand = (r_cand == qecc_pkg::CH_SOLVED) || (r_cand == qecc_pkg::CH_FIRST) ||
                       (r_acc <= r_best);

    // Cost leaves as Q32.32: arithmetic shift by 16, then saturation to 64 bits.
    always_comb begin
        cost_sh = r_best >>> 16;
        if ((&cost_sh[ACC_W-1:63]) || !(|cost_sh[ACC_W-1:63])) begin
            cost_sat = cost_sh[63:0];
        end else if (cost_sh[ACC_W-1]) begin
            cost_sat = 64'sh8000_0000_0000_0000;
        end else begin
            cost_sat = 64'sh7FFF_FFFF_FFFF_FFFF;
        end
    end

    assign out_load = (r_state == S_OUT) && (!r_ovalid || !i_out_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            // A new result replaces the old one in the cycle the old one leaves.
            if (out_load) begin
                r_ovalid <= 1'b1;
            end else if (r_ovalid && !i_out_stall) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_take) begin
                        if (i_slot <= qecc_pkg::OP_Q9) begin
                            r_q[i_slot] <= {i_first_value[PW-1], i_first_value} +
                                           {i_second_value[PW-1], i_second_value};
                        end else if (i_slot <= qecc_pkg::OP_PZ) begin
                            r_first[2'(i_slot - qecc_pkg::OP_PX)]  <= i_first_value;
                            r_second[2'(i_slot - qecc_pkg::OP_PX)] <= i_second_value;
                        end
                        if (i_last) begin
                            r_phase <= qecc_pkg::PH_DET;
                            r_term  <= '0;
                            r_acc   <= '0;
                            r_state <= S_TERM_A;
                        end
                    end
                end
                S_TERM_A: begin
                    r_ma    <= opnd_val;
                    r_state <= S_TERM_B;
                end
                S_TERM_B: begin
                    r_state <= S_MUL1;
                end
                S_MUL1: begin
                    if (mul_done) begin
                        r_state <= S_TERM_C;
                    end
                end
                S_TERM_C: begin
                    r_state <= S_MUL2;
                end
                S_MUL2: begin
                    if (mul_done) begin
                        r_acc <= term.sub ? (r_acc - mul_prod) : (r_acc + mul_prod);
                        if (r_term == qecc_pkg::term_last(r_phase)) begin
                            r_state <= S_PHASE_END;
                        end else begin
                            r_term  <= r_term + 1'b1;
                            r_state <= S_TERM_A;
                        end
                    end
                end
                S_PHASE_END: begin
                    r_term <= '0;
                    unique case (r_phase)
                        qecc_pkg::PH_DET: begin
                            r_det   <= r_acc;
                            r_acc   <= '0;
                            r_state <= S_TERM_A;
                            if (r_acc != '0) begin
                                r_phase <= qecc_pkg::PH_COFX;
                            end else begin
                                r_phase <= qecc_pkg::PH_EVAL;
                                r_cand  <= qecc_pkg::CH_FIRST;
                                r_p     <= r_first;
                            end
                        end
                        qecc_pkg::PH_COFX, qecc_pkg::PH_COFY, qecc_pkg::PH_COFZ: begin
                            r_state <= S_DIV;
                        end
                        default: begin
                            if (take_cand) begin
                                r_best <= r_acc;
                                r_bpos <= r_p;
                                r_bch  <= r_cand;
                            end
                            r_acc <= '0;
                            if (r_cand == qecc_pkg::CH_FIRST) begin
                                r_p     <= r_second;
                                r_cand  <= qecc_pkg::CH_SECOND;
                                r_state <= S_TERM_A;
                            end else if (r_cand == qecc_pkg::CH_SECOND) begin
                                r_p     <= mid;
                                r_cand  <= qecc_pkg::CH_MID;
                                r_state <= S_TERM_A;
                            end else begin
                                r_state <= S_OUT;
                            end
                        end
                    endcase
                end
                S_DIV: begin
                    if (div_done) begin
                        r_acc   <= '0;
                        r_state <= S_TERM_A;
                        unique case (r_phase)
                            qecc_pkg::PH_COFX: begin
                                r_p[0]  <= div_quot;
                                r_phase <= qecc_pkg::PH_COFY;
                            end
                            qecc_pkg::PH_COFY: begin
                                r_p[1]  <= div_quot;
                                r_phase <= qecc_pkg::PH_COFZ;
                            end
                            default: begin
                                r_p[2]  <= div_quot;
                                r_phase <= qecc_pkg::PH_EVAL;
                                r_cand  <= qecc_pkg::CH_SOLVED;
                            end
                        endcase
                    end
                end
                S_OUT: begin
                    if (out_load) begin
                        r_o_cost   <= cost_sat;
                        r_o_pos    <= r_bpos;
                        r_o_choice <= r_bch;
                        r_state    <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_ovalid;
    assign o_cost      = r_o_cost;
    assign o_pos_x     = r_o_pos[0];
    assign o_pos_y     = r_o_pos[1];
    assign o_pos_z     = r_o_pos[2];
    assign o_choice    = r_o_choice;

    // A solved position is only reported when the determinant was nonzero.
    a_solved_needs_det: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_load && (r_bch == qecc_pkg::CH_SOLVED)) |-> (r_det != '0))
        else $error("solved choice with zero determinant");

    // The divider answers only while the sequencer waits for it.
    a_div_done_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> (r_state == S_DIV))
        else $error("divider finished outside its wait state");

    // The multiplier answers only while the sequencer waits for a product.
    a_mul_done_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mul_done |-> ((r_state == S_MUL1) || (r_state == S_MUL2)))
        else $error("multiplier finished outside a product wait");

endmodule
`default_nettype wire
